[rtl/ttsc_pkg.sv]
package ttsc_pkg;

    localparam int SAMPLE_W        = 10;
    localparam int COUNT_W         = 16;
    localparam int OFFSET_W        = 10;
    localparam int OFF_LIMIT       = 1024;
    localparam int STORE_DEPTH_DEF = 1024;
    localparam int QUEUE_DEPTH     = 4;
    localparam int CFG_ADDR_W      = 3;
    localparam int CFG_DATA_W      = 32;

    localparam logic [SAMPLE_W-1:0] TRIGGER_LEVEL_RST = SAMPLE_W'(500);
    localparam logic [COUNT_W-1:0]  POST_END_RST      = COUNT_W'(500);

    // request codes on the input channel
    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_REARM  = 2'd2;

    // register word index (paddr[2])
    localparam logic REG_TRIGGER_LEVEL = 1'b0;
    localparam logic REG_POST_END      = 1'b1;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_READ   = 2'd1,
        OP_REARM  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [SAMPLE_W-1:0] sample;
        logic [OFFSET_W-1:0] offset;
    } t_cmd;

    typedef struct packed {
        logic [SAMPLE_W-1:0] trigger_level;
        logic [COUNT_W-1:0]  post_end;
    } t_cfg;

endpackage

[rtl/ttsc_if.sv]
interface ttsc_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    req_type;
    logic [ttsc_pkg::SAMPLE_W-1:0] sample_value;
    logic [ttsc_pkg::OFFSET_W-1:0] read_offset;

    modport source(output valid, req_type, sample_value, read_offset, input ready);
    modport sink(input valid, req_type, sample_value, read_offset, output ready);
endinterface

interface ttsc_res_if;
    logic                          valid;
    logic                          ready;
    logic [ttsc_pkg::SAMPLE_W-1:0] read_data;
    logic                          trigger_active;
    logic                          capture_done;

    modport source(output valid, read_data, trigger_active, capture_done, input ready);
    modport sink(input valid, read_data, trigger_active, capture_done, output ready);
endinterface

[rtl/ttsc_ram.sv]
module ttsc_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/ttsc_front.sv]
module ttsc_front #(
    parameter int STORE_DEPTH = ttsc_pkg::STORE_DEPTH_DEF
) (
    ttsc_req_if.sink         i_req,
    output logic             o_cmd_valid,
    input  logic             i_cmd_ready,
    output ttsc_pkg::t_cmd   o_cmd
);

    // restoring reduction of the offset by multiples of the depth
    localparam int RED_STEPS = (STORE_DEPTH >= ttsc_pkg::OFF_LIMIT) ? 0 :
        $clog2((ttsc_pkg::OFF_LIMIT + STORE_DEPTH - 1) / STORE_DEPTH);

    logic [ttsc_pkg::OFFSET_W-1:0] off_red;

    always_comb begin
        off_red = i_req.read_offset;
        for (int k = RED_STEPS - 1; k >= 0; k--) begin
            if (32'(off_red) >= (STORE_DEPTH << k)) begin
                off_red = off_red - ttsc_pkg::OFFSET_W'(STORE_DEPTH << k);
            end
        end
    end

    always_comb begin
        o_cmd.sample = i_req.sample_value;
        o_cmd.offset = off_red;
        case (i_req.req_type)
            ttsc_pkg::REQ_SAMPLE: o_cmd.op = ttsc_pkg::OP_SAMPLE;
            ttsc_pkg::REQ_READ:   o_cmd.op = ttsc_pkg::OP_READ;
            ttsc_pkg::REQ_REARM:  o_cmd.op = ttsc_pkg::OP_REARM;
            default:              o_cmd.op = ttsc_pkg::OP_NONE;
        endcase
    end

    assign o_cmd_valid = i_req.valid;
    assign i_req.ready = i_cmd_ready;

endmodule

[rtl/ttsc_queue.sv]
module ttsc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  ttsc_pkg::t_cmd i_push,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output ttsc_pkg::t_cmd o_pop
);

    localparam int PW = $clog2(ttsc_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(ttsc_pkg::QUEUE_DEPTH + 1);

    ttsc_pkg::t_cmd r_slot [ttsc_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;
    logic           push, pop;

    assign o_push_ready = (r_count != CW'(ttsc_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop        = r_slot[r_rd_ptr];

    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = push ? PW'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = pop  ? PW'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = CW'(r_count + 1'b1);
        end else if (pop && !push) begin
            n_count = CW'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push;
        end
    end

endmodule

[rtl/ttsc_back.sv]
module ttsc_back #(
    parameter int STORE_DEPTH = ttsc_pkg::STORE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    input  ttsc_pkg::t_cmd i_cmd,
    input  ttsc_pkg::t_cfg i_cfg,
    ttsc_res_if.source     o_res
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int SW = ((AW > ttsc_pkg::OFFSET_W) ? AW : ttsc_pkg::OFFSET_W) + 1;

    logic [AW-1:0]                r_wi, n_wi;
    logic [ttsc_pkg::COUNT_W-1:0] r_post, n_post;
    logic                         r_done, n_done;
    logic                         r_full, n_full;

    logic                          r_out_valid;
    logic                          r_out_read, n_out_read;
    logic                          r_out_ok, n_out_ok;
    logic                          r_out_active;
    logic                          r_out_done;

    logic                          fire;
    logic                          wr_en, rd_en;
    logic [AW-1:0]                 wi_next;
    logic [SW-1:0]                 pos_sum;
    logic [AW-1:0]                 pos;
    logic [ttsc_pkg::COUNT_W-1:0]  post_inc;
    logic [ttsc_pkg::SAMPLE_W-1:0] ram_q;

    assign o_cmd_ready = !r_out_valid || o_res.ready;
    assign fire        = i_cmd_valid && o_cmd_ready;

    assign wi_next  = (r_wi == AW'(STORE_DEPTH - 1)) ? '0 : AW'(r_wi + 1'b1);
    assign post_inc = ttsc_pkg::COUNT_W'(r_post + 1'b1);

    // oldest entry sits just after the write index
    always_comb begin
        pos_sum = SW'(r_wi) + SW'(1) + SW'(i_cmd.offset);
        if (pos_sum >= SW'(STORE_DEPTH)) begin
            pos_sum = pos_sum - SW'(STORE_DEPTH);
        end
        pos = AW'(pos_sum);
    end

    always_comb begin
        n_wi       = r_wi;
        n_post     = r_post;
        n_done     = r_done;
        n_full     = r_full;
        n_out_read = 1'b0;
        n_out_ok   = 1'b0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        if (fire) begin
            case (i_cmd.op)
                ttsc_pkg::OP_SAMPLE: begin
                    if (!r_done) begin
                        if (r_post != '0) begin
                            n_post = post_inc;
                            if (post_inc == i_cfg.post_end) begin
                                n_post = '0;
                                n_done = 1'b1;
                            end
                        end else if (i_cmd.sample >= i_cfg.trigger_level) begin
                            n_post = ttsc_pkg::COUNT_W'(1);
                        end
                        n_wi   = wi_next;
                        wr_en  = 1'b1;
                        // index zero is the last to be filled
                        n_full = r_full || (wi_next == '0);
                    end
                end
                ttsc_pkg::OP_READ: begin
                    rd_en      = 1'b1;
                    n_out_read = 1'b1;
                    // entries never written read as zero
                    n_out_ok   = r_full || ((pos != '0) && (pos <= r_wi));
                end
                ttsc_pkg::OP_REARM: begin
                    n_done = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    ttsc_ram #(
        .WIDTH(ttsc_pkg::SAMPLE_W),
        .DEPTH(STORE_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(wi_next),
        .i_wdata(i_cmd.sample),
        .i_re   (rd_en),
        .i_raddr(pos),
        .o_rdata(ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wi        <= '0;
            r_post      <= '0;
            r_done      <= 1'b0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wi   <= n_wi;
            r_post <= n_post;
            r_done <= n_done;
            r_full <= n_full;
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_read   <= n_out_read;
            r_out_ok     <= n_out_ok;
            r_out_active <= (n_post != '0);
            r_out_done   <= n_done;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.read_data      = (r_out_read && r_out_ok) ? ram_q : '0;
    assign o_res.trigger_active = r_out_active;
    assign o_res.capture_done   = r_out_done;

endmodule

[rtl/threshold_triggered_sample_capture_unit.sv]
// channel   dir  handshake      payload
// i_req     in   valid/ready    req_type[1:0] sample_value[9:0] read_offset[9:0]
// o_res     out  valid/ready    read_data[9:0] trigger_active capture_done
// apb       in   psel/penable   paddr[2:0] pwdata[31:0] prdata[31:0], pready tied high
//
// one request per cycle sustained while o_res is ready; a request is written into the
// command queue, popped from it by the back end, and its result (with the store read) is
// registered in the output stage, from which it transfers on o_res
// i_rst_n is synchronous; no clearing sweep, a fill flag makes unwritten entries read zero
// a four-entry command queue lets input transfers continue while o_res stalls
module threshold_triggered_sample_capture_unit #(
    parameter int STORE_DEPTH = ttsc_pkg::STORE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    ttsc_req_if.sink                        i_req,
    ttsc_res_if.source                      o_res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ttsc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [ttsc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [ttsc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);

    ttsc_pkg::t_cfg r_cfg;
    ttsc_pkg::t_cmd front_cmd, queue_cmd;
    logic           front_valid, front_ready;
    logic           queue_valid, queue_ready;
    logic           cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_level <= ttsc_pkg::TRIGGER_LEVEL_RST;
            r_cfg.post_end      <= ttsc_pkg::POST_END_RST;
        end else if (cfg_write) begin
            case (paddr[2])
                ttsc_pkg::REG_TRIGGER_LEVEL:
                    r_cfg.trigger_level <= pwdata[ttsc_pkg::SAMPLE_W-1:0];
                ttsc_pkg::REG_POST_END:
                    r_cfg.post_end <= pwdata[ttsc_pkg::COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            ttsc_pkg::REG_TRIGGER_LEVEL:
                prdata = ttsc_pkg::CFG_DATA_W'(r_cfg.trigger_level);
            ttsc_pkg::REG_POST_END:
                prdata = ttsc_pkg::CFG_DATA_W'(r_cfg.post_end);
            default:
                prdata = '0;
        endcase
    end

    ttsc_front #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_front (
        .i_req      (i_req),
        .o_cmd_valid(front_valid),
        .i_cmd_ready(front_ready),
        .o_cmd      (front_cmd)
    );

    ttsc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_valid(front_valid),
        .o_push_ready(front_ready),
        .i_push      (front_cmd),
        .o_pop_valid (queue_valid),
        .i_pop_ready (queue_ready),
        .o_pop       (queue_cmd)
    );

    ttsc_back #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(queue_valid),
        .o_cmd_ready(queue_ready),
        .i_cmd      (queue_cmd),
        .i_cfg      (r_cfg),
        .o_res      (o_res)
    );

endmodule

[rtl/ttsc_checker.sv]
module ttsc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_res_valid,
    input logic                            i_res_ready,
    input logic [ttsc_pkg::SAMPLE_W-1:0]   i_res_data,
    input logic                            i_res_active,
    input logic                            i_res_done,
    input logic                            i_psel,
    input logic                            i_penable,
    input logic                            i_pwrite,
    input logic [ttsc_pkg::CFG_ADDR_W-1:0] i_paddr,
    input logic [ttsc_pkg::CFG_DATA_W-1:0] i_pwdata,
    input logic [ttsc_pkg::CFG_DATA_W-1:0] i_prdata
);

    // a stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_data)
            && $stable(i_res_active) && $stable(i_res_done))
        else $error("result changed while stalled");

    // a finished capture never has a count running
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> !(i_res_active && i_res_done))
        else $error("trigger active together with capture done");

    // trigger level reads back what was written
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_psel && i_penable && i_pwrite && (i_paddr[2] == ttsc_pkg::REG_TRIGGER_LEVEL))
            ##1 (i_psel && !i_pwrite && (i_paddr[2] == ttsc_pkg::REG_TRIGGER_LEVEL))
        |-> (i_prdata[ttsc_pkg::SAMPLE_W-1:0] == $past(i_pwdata[ttsc_pkg::SAMPLE_W-1:0]))
            && (i_prdata[ttsc_pkg::CFG_DATA_W-1:ttsc_pkg::SAMPLE_W] == '0))
        else $error("trigger level readback mismatch");

endmodule

bind threshold_triggered_sample_capture_unit ttsc_checker u_ttsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_data  (o_res.read_data),
    .i_res_active(o_res.trigger_active),
    .i_res_done  (o_res.capture_done),
    .i_psel      (psel),
    .i_penable   (penable),
    .i_pwrite    (pwrite),
    .i_paddr     (paddr),
    .i_pwdata    (pwdata),
    .i_prdata    (prdata)
);

[tb/sv/threshold_triggered_sample_capture_unit_test.sv]
class capture_tracker;
    typedef struct packed {
        logic [ttsc_pkg::SAMPLE_W-1:0] read_data;
        logic                          trigger_active;
        logic                          capture_done;
    } t_readout;

    logic [ttsc_pkg::SAMPLE_W-1:0] samples [ttsc_pkg::STORE_DEPTH_DEF];
    int                            wr_ptr;
    logic [ttsc_pkg::COUNT_W-1:0]  post_cnt;
    bit                            frozen;
    logic [ttsc_pkg::SAMPLE_W-1:0] level;
    logic [ttsc_pkg::COUNT_W-1:0]  stop_at;
    t_readout                      pending_readouts[$];
    int                            mismatches;

    function new();
        foreach (samples[i]) samples[i] = '0;
        wr_ptr     = 0;
        post_cnt   = '0;
        frozen     = 0;
        level      = ttsc_pkg::TRIGGER_LEVEL_RST;
        stop_at    = ttsc_pkg::POST_END_RST;
        mismatches = 0;
    endfunction

    function void note_request(ttsc_pkg::t_op op, logic [ttsc_pkg::SAMPLE_W-1:0] smp,
                               logic [ttsc_pkg::OFFSET_W-1:0] off);
        t_readout r;
        int       pos;
        r = '0;
        case (op)
            ttsc_pkg::OP_SAMPLE: begin
                if (!frozen) begin
                    if (post_cnt != '0) begin
                        post_cnt = post_cnt + 1'b1;
                        if (post_cnt == stop_at) begin
                            post_cnt = '0;
                            frozen   = 1;
                        end
                    end else if (smp >= level) begin
                        post_cnt = 1;
                    end
                    wr_ptr          = (wr_ptr + 1) % ttsc_pkg::STORE_DEPTH_DEF;
                    samples[wr_ptr] = smp;
                end
            end
            ttsc_pkg::OP_READ: begin
                // oldest entry sits just after the write pointer
                pos         = (wr_ptr + 1 + int'(off)) % ttsc_pkg::STORE_DEPTH_DEF;
                r.read_data = samples[pos];
            end
            ttsc_pkg::OP_REARM: begin
                frozen = 0;
            end
            default: begin
            end
        endcase
        r.trigger_active = (post_cnt != '0);
        r.capture_done   = frozen;
        pending_readouts.push_back(r);
    endfunction

    function void check_result(logic [ttsc_pkg::SAMPLE_W-1:0] rd, logic ta, logic cd);
        t_readout exp_r;
        if (pending_readouts.size() == 0) begin
            $error("result transfer with nothing pending: read_data %0d", rd);
            mismatches++;
            return;
        end
        exp_r = pending_readouts.pop_front();
        if (rd !== exp_r.read_data) begin
            $error("read_data: expected %0d, actual %0d", exp_r.read_data, rd);
            mismatches++;
        end
        if (ta !== exp_r.trigger_active) begin
            $error("trigger_active: expected %0d, actual %0d", exp_r.trigger_active, ta);
            mismatches++;
        end
        if (cd !== exp_r.capture_done) begin
            $error("capture_done: expected %0d, actual %0d", exp_r.capture_done, cd);
            mismatches++;
        end
    endfunction
endclass

module threshold_triggered_sample_capture_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 2000;
    localparam logic [ttsc_pkg::CFG_ADDR_W-1:0] ADDR_LEVEL =
        {ttsc_pkg::REG_TRIGGER_LEVEL, 2'b00};
    localparam logic [ttsc_pkg::CFG_ADDR_W-1:0] ADDR_END =
        {ttsc_pkg::REG_POST_END, 2'b00};

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [ttsc_pkg::CFG_ADDR_W-1:0] paddr;
    logic [ttsc_pkg::CFG_DATA_W-1:0] pwdata;
    logic [ttsc_pkg::CFG_DATA_W-1:0] prdata;
    logic                            pready;

    ttsc_req_if req_ch();
    ttsc_res_if res_ch();

    threshold_triggered_sample_capture_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    capture_tracker trk = new();
    bit req_live;
    bit calm;
    int cfg_errors;
    int idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // result side stalls
    initial begin
        int run;
        int stall;
        @(posedge i_clk);
        forever begin
            res_ch.ready <= 1'b1;
            run = $urandom_range(12, 1);
            repeat (run) @(posedge i_clk);
            stall = pick_gap();
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            trk.check_result(res_ch.read_data, res_ch.trigger_active, res_ch.capture_done);
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send(input ttsc_pkg::t_op op, input logic [ttsc_pkg::SAMPLE_W-1:0] smp,
                        input logic [ttsc_pkg::OFFSET_W-1:0] off);
        int gap;
        req_ch.req_type     <= op;
        req_ch.sample_value <= smp;
        req_ch.read_offset  <= off;
        if (!req_live) begin
            req_ch.valid <= 1'b1;
            req_live = 1;
        end
        do @(posedge i_clk); while (!req_ch.ready);
        trk.note_request(op, smp, off);
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            req_live = 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_dir(input ttsc_pkg::t_op op, input int smp, input int off);
        send(op, ttsc_pkg::SAMPLE_W'(smp), ttsc_pkg::OFFSET_W'(off));
    endtask

    task automatic settle();
        if (req_live) begin
            req_ch.valid <= 1'b0;
            req_live = 0;
        end
        while (trk.pending_readouts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic [ttsc_pkg::CFG_ADDR_W-1:0] addr, input logic wr,
                              input logic [ttsc_pkg::CFG_DATA_W-1:0] wdata,
                              output logic [ttsc_pkg::CFG_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_register(input logic [ttsc_pkg::CFG_ADDR_W-1:0] addr,
                                    input int value);
        logic [ttsc_pkg::CFG_DATA_W-1:0] rd;
        logic [ttsc_pkg::CFG_DATA_W-1:0] want;
        if (addr == ADDR_LEVEL) begin
            trk.level = ttsc_pkg::SAMPLE_W'(value);
            want      = ttsc_pkg::CFG_DATA_W'(trk.level);
        end else begin
            trk.stop_at = ttsc_pkg::COUNT_W'(value);
            want        = ttsc_pkg::CFG_DATA_W'(trk.stop_at);
        end
        apb_access(addr, 1'b1, ttsc_pkg::CFG_DATA_W'(value), rd);
        apb_access(addr, 1'b0, '0, rd);
        if (rd !== want) begin
            $error("prdata: expected %0d, actual %0d", want, rd);
            cfg_errors++;
        end
    endtask

    task automatic setup_capture(input int lvl, input int stop_val);
        settle();
        program_register(ADDR_LEVEL, lvl);
        program_register(ADDR_END, stop_val);
    endtask

    function automatic logic [ttsc_pkg::SAMPLE_W-1:0] pick_sample(int lvl);
        int v;
        case ($urandom_range(3))
            2: begin
                v = lvl - 3 + int'($urandom_range(6));
                if (v < 0) v = 0;
                if (v > 1023) v = 1023;
            end
            3: v = (lvl == 0) ? 0 : int'($urandom_range(lvl - 1));
            default: v = $urandom_range(1023);
        endcase
        return ttsc_pkg::SAMPLE_W'(v);
    endfunction

    function automatic logic [ttsc_pkg::OFFSET_W-1:0] pick_offset();
        case ($urandom_range(7))
            0: return '1;
            1: return '0;
            2: return ttsc_pkg::OFFSET_W'($urandom_range(1023, 1015));
            default: return ttsc_pkg::OFFSET_W'($urandom_range(1023));
        endcase
    endfunction

    task automatic run_phase(input int lvl, input int stop_val, input int n, input bit quiet);
        int            counted;
        int            r;
        ttsc_pkg::t_op op;
        setup_capture(lvl, stop_val);
        calm    = quiet;
        counted = 0;
        while (counted < n) begin
            r = $urandom_range(99);
            // mostly samples; rearm more often once the buffer froze
            if (r < 60)                         op = ttsc_pkg::OP_SAMPLE;
            else if (r < 82)                    op = ttsc_pkg::OP_READ;
            else if (r < 96 || trk.frozen)      op = ttsc_pkg::OP_REARM;
            else                                op = ttsc_pkg::OP_NONE;
            send(op,
                 (op == ttsc_pkg::OP_READ) ? ttsc_pkg::SAMPLE_W'($urandom) : pick_sample(lvl),
                 (op == ttsc_pkg::OP_READ) ? pick_offset() : ttsc_pkg::OFFSET_W'($urandom));
            counted++;
        end
        calm = 0;
    endtask

    initial begin
        i_rst_n             = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = ttsc_pkg::OP_SAMPLE;
        req_ch.sample_value = '0;
        req_ch.read_offset  = '0;
        res_ch.ready        = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        req_live            = 0;
        calm                = 0;
        cfg_errors          = 0;
        idle_cycles         = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset thresholds, empty buffer
        send_dir(ttsc_pkg::OP_READ, 0, 0);
        send_dir(ttsc_pkg::OP_READ, 0, 1023);
        send_dir(ttsc_pkg::OP_NONE, 1023, 1023);
        send_dir(ttsc_pkg::OP_REARM, 0, 0);
        send_dir(ttsc_pkg::OP_SAMPLE, 0, 0);
        send_dir(ttsc_pkg::OP_SAMPLE, 499, 0);
        send_dir(ttsc_pkg::OP_SAMPLE, 500, 0);
        send_dir(ttsc_pkg::OP_SAMPLE, 1023, 0);
        send_dir(ttsc_pkg::OP_READ, 0, 1023);
        send_dir(ttsc_pkg::OP_READ, 0, 1022);

        // shortest capture at the top threshold
        setup_capture(1023, 2);
        send_dir(ttsc_pkg::OP_SAMPLE, 1022, 0);
        send_dir(ttsc_pkg::OP_SAMPLE, 1023, 0);
        send_dir(ttsc_pkg::OP_SAMPLE, 0, 0);
        send_dir(ttsc_pkg::OP_SAMPLE, 5, 0);
        send_dir(ttsc_pkg::OP_READ, 0, 1023);
        send_dir(ttsc_pkg::OP_READ, 0, 1022);
        send_dir(ttsc_pkg::OP_REARM, 0, 0);
        send_dir(ttsc_pkg::OP_REARM, 0, 0);
        send_dir(ttsc_pkg::OP_SAMPLE, 1023, 0);
        send_dir(ttsc_pkg::OP_NONE, 0, 0);

        run_phase(0, 2, 200, 1);
        run_phase(1023, 65535, 150, 0);
        run_phase(300, 6, 250, 0);
        run_phase(520, 40, 250, 1);
        run_phase(700, 0, 150, 0);
        run_phase(200, 1, 150, 0);
        run_phase(800, 500, 250, 0);
        run_phase($urandom_range(1023), $urandom_range(64, 2), 225, 0);
        run_phase($urandom_range(1023), $urandom_range(64, 2), 225, 0);

        settle();
        repeat (8) @(posedge i_clk);
        if (trk.mismatches == 0 && cfg_errors == 0 && trk.pending_readouts.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
